>>> hdl/clnw_pkg.sv
// Shared types, constants and helper functions for the character LCD nibble writer.
package clnw_pkg;

  localparam int LINE_CHARS_DEF = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int INIT_STROBES = 14;
  localparam int INIT_PRESET_STROBES = 4;

  localparam logic [2:0] CMD_INIT = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_HEX = 3'd3;
  localparam logic [2:0] CMD_DEC = 3'd4;

  localparam logic [7:0] LCD_LINE2 = 8'hC0;
  localparam logic [7:0] LCD_HOME = 8'h80;
  localparam logic [7:0] LCD_CLEAR = 8'h01;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_HEX_BASE = 8'h37;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_CLEAR,
    OP_CHARS
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic [1:0] n_chars;
    logic [2:0][7:0] chars;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_INIT,
    BK_CLEAR,
    BK_LINE2,
    BK_HOME,
    BK_DATA
  } back_state_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] step);
    logic [3:0] nib;
    case (step)
      4'd0: nib = 4'h3;
      4'd1: nib = 4'h3;
      4'd2: nib = 4'h3;
      4'd3: nib = 4'h2;
      4'd4: nib = 4'h0;
      4'd5: nib = 4'h8;
      4'd6: nib = 4'h0;
      4'd7: nib = 4'hF;
      4'd8: nib = 4'h0;
      4'd9: nib = 4'h6;
      4'd10: nib = 4'h0;
      4'd11: nib = 4'h1;
      4'd12: nib = 4'h0;
      4'd13: nib = 4'h2;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d >= 4'd10) begin
      c = {4'h0, d} + ASCII_HEX_BASE;
    end else begin
      c = {4'h0, d} + ASCII_ZERO;
    end
    return c;
  endfunction

endpackage

>>> hdl/char_lcd_nibble_writer_core.sv
// Top level of the character LCD nibble writer: front end, operation queue and strobe sequencer.
// Each accepted request becomes up to fourteen enable strobes, one per clock at most, for a
// character LCD driven in 4-bit mode. The strobe sequencer sets the pace: a request costs one
// strobe per nibble (init 14, clear 4, each printed character 2, plus 2 before the character at
// the start of line two and 4 before the one that wraps the screen); a request reaching an idle
// sequencer is loaded before strobing. A four-entry queue lets new requests be taken while
// earlier ones are still being sent; decimal zero and unused command codes produce nothing.
module char_lcd_nibble_writer_core #(
  parameter int LINE_CHARS = clnw_pkg::LINE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_register_select,
  output logic [3:0] out_nibble,
  output logic [4:0] out_port_bits,
  output logic       out_wait_class,
  output logic       out_power_up_wait,
  output logic       out_last
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_head_valid;
  clnw_pkg::op_t q_push_data;
  clnw_pkg::op_t q_head_data;

  clnw_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_value   (in_value),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  clnw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  clnw_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (q_head_valid),
    .head_data           (q_head_data),
    .pop                 (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_port_bits       (out_port_bits),
    .out_wait_class      (out_wait_class),
    .out_power_up_wait   (out_power_up_wait),
    .out_last            (out_last)
  );

endmodule

>>> hdl/clnw_front.sv
// Front end: accepts requests, converts them into display operations for the queue.
module clnw_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_command,
  input  logic [7:0]       in_value,
  input  logic             q_full,
  output logic             q_push,
  output clnw_pkg::op_t    q_data
);

  logic [1:0]  hund;
  logic [7:0]  rem_h;
  logic [15:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic        has_op;

  always_comb begin
    if (in_value >= 8'd200) begin
      hund = 2'd2;
    end else if (in_value >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem_h = in_value - 8'(hund) * 8'd100;
    tens_prod = {8'h00, rem_h} * 16'd205;
    tens = tens_prod[14:11];
    ones = 4'(rem_h - {tens, 3'b000} - {3'b000, tens, 1'b0});
  end

  always_comb begin
    q_data = '0;
    q_data.kind = clnw_pkg::OP_CHARS;
    has_op = 1'b1;
    case (in_command)
      clnw_pkg::CMD_INIT: begin
        q_data.kind = clnw_pkg::OP_INIT;
      end
      clnw_pkg::CMD_CLEAR: begin
        q_data.kind = clnw_pkg::OP_CLEAR;
      end
      clnw_pkg::CMD_WRITE: begin
        q_data.n_chars = 2'd1;
        q_data.chars[0] = in_value;
      end
      clnw_pkg::CMD_HEX: begin
        q_data.n_chars = 2'd2;
        q_data.chars[0] = clnw_pkg::hex_char(in_value[7:4]);
        q_data.chars[1] = clnw_pkg::hex_char(in_value[3:0]);
      end
      clnw_pkg::CMD_DEC: begin
        if (hund != 2'd0) begin
          q_data.n_chars = 2'd3;
          q_data.chars[0] = {6'h0, hund} + clnw_pkg::ASCII_ZERO;
          q_data.chars[1] = {4'h0, tens} + clnw_pkg::ASCII_ZERO;
          q_data.chars[2] = {4'h0, ones} + clnw_pkg::ASCII_ZERO;
        end else if (tens != 4'd0) begin
          q_data.n_chars = 2'd2;
          q_data.chars[0] = {4'h0, tens} + clnw_pkg::ASCII_ZERO;
          q_data.chars[1] = {4'h0, ones} + clnw_pkg::ASCII_ZERO;
        end else if (ones != 4'd0) begin
          q_data.n_chars = 2'd1;
          q_data.chars[0] = {4'h0, ones} + clnw_pkg::ASCII_ZERO;
        end else begin
          has_op = 1'b0;
        end
      end
      default: begin
        has_op = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push = in_valid && !q_full && has_op;

endmodule

>>> hdl/clnw_queue.sv
// Short queue of display operations between the front end and the strobe sequencer.
module clnw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  clnw_pkg::op_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output clnw_pkg::op_t  head_data
);

  localparam int AW = clnw_pkg::QUEUE_AW;

  clnw_pkg::op_t mem_r [clnw_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full = (count_r == (AW+1)'(clnw_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/clnw_back.sv
// Back end: expands queued operations into enable strobes and keeps the cursor count.
module clnw_back #(
  parameter int LINE_CHARS = clnw_pkg::LINE_CHARS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  clnw_pkg::op_t  head_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_register_select,
  output logic [3:0]     out_nibble,
  output logic [4:0]     out_port_bits,
  output logic           out_wait_class,
  output logic           out_power_up_wait,
  output logic           out_last
);

  localparam int CW = $clog2(2 * LINE_CHARS + 2);
  localparam logic [CW-1:0] LINE_POS = CW'(LINE_CHARS);
  localparam logic [CW-1:0] WRAP_POS = CW'(2 * LINE_CHARS);

  clnw_pkg::back_state_t state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [1:0]    idx_r, idx_nxt;
  clnw_pkg::op_t op_r, op_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          rs_r;
  logic [3:0]    nib_r;
  logic          wait_r;
  logic          pwr_r;
  logic          last_r;

  logic          out_free;
  logic          emit;
  logic          s_rs;
  logic [3:0]    s_nib;
  logic          s_wait;
  logic          s_pwr;
  logic          s_last;
  logic [7:0]    cur_char;

  always_comb begin
    logic          op_done;
    logic          char_start;
    logic          load;
    logic [CW-1:0] base;

    state_nxt = state_r;
    step_nxt = step_r;
    idx_nxt = idx_r;
    op_nxt = op_r;
    cursor_nxt = cursor_r;
    pop = 1'b0;
    emit = 1'b0;
    op_done = 1'b0;
    char_start = 1'b0;
    load = 1'b0;
    base = cursor_r;
    cur_char = op_r.chars[idx_r];
    out_free = !out_valid_r || !out_stall;

    s_rs = 1'b0;
    s_nib = 4'h0;
    s_wait = 1'b0;
    s_pwr = 1'b0;
    s_last = 1'b0;
    case (state_r)
      clnw_pkg::BK_INIT: begin
        s_nib = clnw_pkg::init_nibble(step_r);
        s_wait = (step_r < 4'(clnw_pkg::INIT_PRESET_STROBES));
        s_pwr = (step_r == 4'd0);
        s_last = (step_r == 4'(clnw_pkg::INIT_STROBES - 1));
      end
      clnw_pkg::BK_CLEAR, clnw_pkg::BK_HOME: begin
        case (step_r[1:0])
          2'd0: s_nib = clnw_pkg::LCD_HOME[7:4];
          2'd1: s_nib = clnw_pkg::LCD_HOME[3:0];
          2'd2: s_nib = clnw_pkg::LCD_CLEAR[7:4];
          default: s_nib = clnw_pkg::LCD_CLEAR[3:0];
        endcase
        s_last = (state_r == clnw_pkg::BK_CLEAR) && (step_r == 4'd3);
      end
      clnw_pkg::BK_LINE2: begin
        s_nib = step_r[0] ? clnw_pkg::LCD_LINE2[3:0] : clnw_pkg::LCD_LINE2[7:4];
      end
      clnw_pkg::BK_DATA: begin
        s_rs = 1'b1;
        s_nib = step_r[0] ? cur_char[3:0] : cur_char[7:4];
        s_last = step_r[0] && (idx_r == op_r.n_chars - 2'd1);
      end
      default: begin
        s_nib = 4'h0;
      end
    endcase

    if (state_r == clnw_pkg::BK_IDLE) begin
      load = head_valid;
    end else if (out_free) begin
      emit = 1'b1;
      step_nxt = step_r + 4'd1;
      case (state_r)
        clnw_pkg::BK_INIT: begin
          if (step_r == 4'(clnw_pkg::INIT_STROBES - 1)) begin
            base = '0;
            op_done = 1'b1;
          end
        end
        clnw_pkg::BK_CLEAR: begin
          if (step_r == 4'd3) begin
            base = '0;
            op_done = 1'b1;
          end
        end
        clnw_pkg::BK_LINE2: begin
          if (step_r == 4'd1) begin
            state_nxt = clnw_pkg::BK_DATA;
            step_nxt = '0;
          end
        end
        clnw_pkg::BK_HOME: begin
          if (step_r == 4'd3) begin
            state_nxt = clnw_pkg::BK_DATA;
            step_nxt = '0;
          end
        end
        clnw_pkg::BK_DATA: begin
          if (step_r == 4'd1) begin
            base = cursor_r + 1'b1;
            cursor_nxt = base;
            if (idx_r == op_r.n_chars - 2'd1) begin
              op_done = 1'b1;
            end else begin
              idx_nxt = idx_r + 2'd1;
              char_start = 1'b1;
            end
          end
        end
        default: begin
          op_done = 1'b0;
        end
      endcase
      if (op_done) begin
        cursor_nxt = base;
        if (head_valid) begin
          load = 1'b1;
        end else begin
          state_nxt = clnw_pkg::BK_IDLE;
        end
      end
    end

    if (load) begin
      pop = 1'b1;
      op_nxt = head_data;
      idx_nxt = '0;
      step_nxt = '0;
      case (head_data.kind)
        clnw_pkg::OP_INIT: state_nxt = clnw_pkg::BK_INIT;
        clnw_pkg::OP_CLEAR: state_nxt = clnw_pkg::BK_CLEAR;
        default: char_start = 1'b1;
      endcase
    end

    if (char_start) begin
      step_nxt = '0;
      if (base == LINE_POS) begin
        state_nxt = clnw_pkg::BK_LINE2;
      end else if (base == WRAP_POS) begin
        state_nxt = clnw_pkg::BK_HOME;
        cursor_nxt = '0;
      end else begin
        state_nxt = clnw_pkg::BK_DATA;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clnw_pkg::BK_IDLE;
      step_r <= '0;
      idx_r <= '0;
      cursor_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      idx_r <= idx_nxt;
      cursor_r <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (emit) begin
      rs_r <= s_rs;
      nib_r <= s_nib;
      wait_r <= s_wait;
      pwr_r <= s_pwr;
      last_r <= s_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_register_select = rs_r;
  assign out_nibble = nib_r;
  assign out_port_bits = {nib_r[0], nib_r[1], nib_r[2], nib_r[3], 1'b0};
  assign out_wait_class = wait_r;
  assign out_power_up_wait = pwr_r;
  assign out_last = last_r;

endmodule
